### hdl/rgb_brightness_contrast_saturation_defines.svh
// Assertion macros shared by the colour adjust block.
`ifndef RGB_BRIGHTNESS_CONTRAST_SATURATION_DEFINES_SVH
`define RGB_BRIGHTNESS_CONTRAST_SATURATION_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define RBCS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define RBCS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rbcs_pkg.sv
// Shared types, constants and helpers for the colour adjust block.
`default_nettype none
package rbcs_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned LevelW    = 7;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned IdxW      = 2;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned RadW      = 2 * SqrtSteps;
  localparam int unsigned RemW      = SqrtSteps + 1;

  localparam logic [LevelW-1:0] LevelReset = 7'd50;

  // brightness: x*(level+10)/60, the divide by 60 as a reciprocal (exact here)
  localparam logic [7:0]  BrightOffset = 8'd10;
  localparam logic [16:0] BrightRecip  = 17'd69906;   // ceil(2^22/60)
  // contrast: (level*(x-128)+6400)/50
  localparam logic signed [8:0]  MidGrey      = 9'sd128;
  localparam logic signed [16:0] ContrastBias = 17'sd6400;
  localparam logic [15:0]        ContrastRecip = 16'd41944;  // ceil(2^21/50)
  // saturation: luma weights in Q16, red in the lowest slot
  localparam logic [NumChan-1:0][15:0] LumaWeight = {16'd7471, 16'd38470, 16'd19595};
  localparam logic [5:0]  SatMid   = 6'd50;
  localparam logic [16:0] SatRecip = 17'd83887;       // ceil(2^22/50)

  typedef enum logic [IdxW-1:0] {
    RegBrightness = 2'd0,
    RegContrast   = 2'd1,
    RegSaturation = 2'd2
  } reg_idx_t;

  typedef logic [ChanW-1:0] chan_t;
  typedef chan_t [NumChan-1:0] pix_t;   // index 0 red, 1 green, 2 blue

  typedef struct packed {
    logic [LevelW-1:0] brightness;
    logic [LevelW-1:0] contrast;
    logic [LevelW-1:0] saturation;
  } levels_t;

  typedef struct packed {
    logic valid;
    pix_t pix;
  } pix_word_t;

  // one slot of the square-root chain
  typedef struct packed {
    logic                 valid;
    logic [RadW-1:0]      rad;
    logic [RemW-1:0]      rem;
    logic [SqrtSteps-1:0] root;
    pix_t                 pix;
  } sqrt_word_t;

  function automatic chan_t clamp_chan(input logic [9:0] v);
    clamp_chan = (v > 10'd255) ? 8'd255 : v[ChanW-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/rbcs_in_if.sv
// Input pixel channel.
`default_nettype none
interface rbcs_in_if;
  import rbcs_pkg::*;
  logic  valid;
  logic  ready;
  chan_t in_red;
  chan_t in_green;
  chan_t in_blue;
  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface
`default_nettype wire

### hdl/rbcs_out_if.sv
// Result pixel channel.
`default_nettype none
interface rbcs_out_if;
  import rbcs_pkg::*;
  logic  valid;
  logic  ready;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface
`default_nettype wire

### hdl/rbcs_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface rbcs_cfg_if;
  import rbcs_pkg::*;
  logic              valid;
  logic              ready;
  logic [IdxW-1:0]   index;
  logic [LevelW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/rgb_brightness_contrast_saturation.sv
// Top level of the RGB brightness, contrast and saturation adjust block.
//
//  channel  | role   | word                                  | accepted when
//  ---------+--------+---------------------------------------+---------------------
//  pixel    | sink   | in_red, in_green, in_blue             | valid & ready
//  result   | source | out_red, out_green, out_blue          | valid & ready
//  cfg      | sink   | index (0 bright, 1 contrast, 2 sat)   | valid & ready
//
// One pixel per clock while the chain is not held; stages: 4 tone, 3 luma, 16 square-root
// cells (one root bit each), 4 saturation including the output register.
// The whole chain shifts together; it holds only while the output register
// is full and result.ready is low, so pixel.ready follows that.
// rst clears every valid bit and sets all three levels to 50 (pass-through).
// cfg.ready is always high; writes to index 3 are dropped.
`default_nettype none
`include "rgb_brightness_contrast_saturation_defines.svh"
module rgb_brightness_contrast_saturation (
  input wire logic clk,
  input wire logic rst,
  rbcs_in_if.sink    pixel,
  rbcs_out_if.source result,
  rbcs_cfg_if.sink   cfg
);
  import rbcs_pkg::*;

  levels_t    levels;
  logic       adv;
  pix_word_t  in_word, tone_word, sat_word;
  sqrt_word_t sq_chain [SqrtSteps+1];

  // level registers
  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '{brightness: LevelReset, contrast: LevelReset, saturation: LevelReset};
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegBrightness: levels.brightness <= cfg.data;
        RegContrast:   levels.contrast   <= cfg.data;
        RegSaturation: levels.saturation <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // chain moves unless the output word is stuck
  assign adv         = !sat_word.valid || result.ready;
  assign pixel.ready = adv;
  assign in_word     = '{valid: pixel.valid,
                         pix: {pixel.in_blue, pixel.in_green, pixel.in_red}};

  rbcs_tone u_tone (
    .clk, .rst, .adv, .levels, .in_word, .out_word(tone_word)
  );

  rbcs_luma u_luma (
    .clk, .rst, .adv, .in_word(tone_word), .out_word(sq_chain[0])
  );

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    rbcs_sqrt_cell u_cell (
      .clk, .rst, .adv, .in_word(sq_chain[k]), .out_word(sq_chain[k+1])
    );
  end

  rbcs_sat u_sat (
    .clk, .rst, .adv, .level(levels.saturation),
    .in_word(sq_chain[SqrtSteps]), .out_word(sat_word)
  );

  assign result.valid     = sat_word.valid;
  assign result.out_red   = sat_word.pix[0];
  assign result.out_green = sat_word.pix[1];
  assign result.out_blue  = sat_word.pix[2];

  // checks
  `RBCS_ASSERT_IMP(a_rad_used, clk, rst, sq_chain[SqrtSteps].valid,
    sq_chain[SqrtSteps].rad == '0, "radicand not fully consumed by sqrt chain")
  `RBCS_ASSERT_IMP(a_rem_bound, clk, rst, sq_chain[SqrtSteps].valid,
    sq_chain[SqrtSteps].rem <= {sq_chain[SqrtSteps].root, 1'b0}, "sqrt remainder out of range")
  `RBCS_ASSERT_NXT(a_stall_hold, clk, rst, !adv,
    $stable(sq_chain[SqrtSteps/2]), "sqrt chain moved during a stall")
  `RBCS_ASSERT_IMP(a_rst_empty, clk, 1'b0, $past(rst),
    !result.valid, "result valid straight after reset")

endmodule
`default_nettype wire

### hdl/rbcs_tone.sv
// Brightness and contrast stages, four pipeline registers.
`default_nettype none
module rbcs_tone (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire rbcs_pkg::levels_t   levels,
  input  wire rbcs_pkg::pix_word_t in_word,
  output rbcs_pkg::pix_word_t      out_word
);
  import rbcs_pkg::*;

  logic [3:0] valid;
  logic [7:0] b_gain;
  logic [NumChan-1:0][15:0] b_prod, b_prod_next;
  pix_t b_pix, b_pix_next;
  logic [NumChan-1:0][16:0] c_num, c_num_next;
  pix_t c_pix, c_pix_next;
  logic [32:0] b_quo  [NumChan];
  logic signed [8:0]  c_diff [NumChan];
  logic signed [16:0] c_mul  [NumChan];
  logic [30:0] c_quo  [NumChan];

  // brightness product, then reciprocal multiply and clamp
  always_comb begin
    b_gain = {1'b0, levels.brightness} + BrightOffset;
    for (int i = 0; i < NumChan; i++) begin
      b_prod_next[i] = 16'(in_word.pix[i]) * 16'(b_gain);
      b_quo[i]       = 33'(b_prod[i]) * 33'(BrightRecip);
      b_pix_next[i]  = clamp_chan(b_quo[i][31:22]);
    end
  end

  // contrast numerator about mid grey, negative gives black
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      c_diff[i]     = $signed({1'b0, b_pix[i]}) - MidGrey;
      c_mul[i]      = $signed({1'b0, levels.contrast}) * c_diff[i];
      c_num_next[i] = c_mul[i] + ContrastBias;
      c_quo[i]      = 31'(c_num[i][14:0]) * 31'(ContrastRecip);
      c_pix_next[i] = c_num[i][16] ? '0 : clamp_chan(c_quo[i][30:21]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[2:0], in_word.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_prod <= b_prod_next;
      b_pix  <= b_pix_next;
      c_num  <= c_num_next;
      c_pix  <= c_pix_next;
    end
  end

  assign out_word = '{valid: valid[3], pix: c_pix};

endmodule
`default_nettype wire

### hdl/rbcs_luma.sv
// Weighted sum of squares that feeds the square-root chain.
`default_nettype none
module rbcs_luma (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire rbcs_pkg::pix_word_t in_word,
  output rbcs_pkg::sqrt_word_t     out_word
);
  import rbcs_pkg::*;

  logic [2:0] valid;
  logic [NumChan-1:0][15:0] sq;
  logic [NumChan-1:0][31:0] wsum;
  logic [RadW-1:0] total;
  pix_t pix1, pix2, pix3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[1:0], in_word.valid};
    end
  end

  // square, weight, add
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NumChan; i++) begin
        sq[i]   <= 16'(in_word.pix[i]) * 16'(in_word.pix[i]);
        wsum[i] <= 32'(sq[i]) * 32'(LumaWeight[i]);
      end
      total <= RadW'(wsum[0] + wsum[1] + wsum[2]);
      pix1  <= in_word.pix;
      pix2  <= pix1;
      pix3  <= pix2;
    end
  end

  assign out_word = '{valid: valid[2], rad: total, rem: '0, root: '0, pix: pix3};

endmodule
`default_nettype wire

### hdl/rbcs_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per cycle while the chain advances.
`default_nettype none
module rbcs_sqrt_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire rbcs_pkg::sqrt_word_t in_word,
  output rbcs_pkg::sqrt_word_t      out_word
);
  import rbcs_pkg::*;

  logic            valid;
  sqrt_word_t      word, word_next;
  logic [RemW+1:0] rem_sh, trial, diff;
  logic            take;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh = {in_word.rem, in_word.rad[RadW-1 -: 2]};
    trial  = {1'b0, in_word.root, 2'b01};
    diff   = rem_sh - trial;
    take   = (rem_sh >= trial);
    word_next       = in_word;
    word_next.rad   = {in_word.rad[RadW-3:0], 2'b00};
    word_next.rem   = take ? diff[RemW-1:0] : rem_sh[RemW-1:0];
    word_next.root  = {in_word.root[SqrtSteps-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word <= word_next;
    end
  end

  always_comb begin
    out_word       = word;
    out_word.valid = valid;
  end

endmodule
`default_nettype wire

### hdl/rbcs_sat.sv
// Saturation about luma, four registers ending in the output register.
`default_nettype none
module rbcs_sat (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  adv,
  input  wire logic [rbcs_pkg::LevelW-1:0] level,
  input  wire rbcs_pkg::sqrt_word_t  in_word,
  output rbcs_pkg::pix_word_t        out_word
);
  import rbcs_pkg::*;

  logic [3:0] valid;
  logic signed [NumChan-1:0][17:0] d, d_next;
  logic [21:0] p50;
  logic signed [NumChan-1:0][25:0] n, n_next;
  logic [NumChan-1:0][9:0] q, q_next;
  pix_t res, res_next;
  logic signed [25:0] mul  [NumChan];
  logic [32:0]        quo  [NumChan];

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      // channel in Q8 less luma
      d_next[i] = $signed({2'b00, in_word.pix[i], 8'h00}) - $signed({2'b00, in_word.root});
      // luma*50 + (x-luma)*level; an element of a packed array reads unsigned
      mul[i]    = $signed(d[i]) * $signed({1'b0, level});
      n_next[i] = $signed({4'b0000, p50}) + mul[i];
      // divide by 12800: drop 8 bits, then reciprocal of 50
      quo[i]    = 33'(n[i][23:8]) * 33'(SatRecip);
      q_next[i] = (n[i][25] || (n[i] == '0)) ? '0 : quo[i][31:22];
      res_next[i] = clamp_chan(q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[2:0], in_word.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d   <= d_next;
      p50 <= 22'(in_word.root) * 22'(SatMid);
      n   <= n_next;
      q   <= q_next;
      res <= res_next;
    end
  end

  assign out_word = '{valid: valid[3], pix: res};

endmodule
`default_nettype wire
